// ===== sv/sse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_pkg: shared constants and types of the shell sort engine
// Key, position and config widths and types used by front, back and top level.
// ----------------------------------------------------------------------------
package sse_pkg;
	localparam int MAX_ITEMS_DEF = 64;
	localparam int KEY_BITS_DEF = 32;
	localparam int IN_KEY_W = 32;
	localparam int OUT_KEY_W = 32;
	localparam int POS_W = 6;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-1:0] REG_SIGNED_KEYS = 1'b0;

	// request passed from front to back through the queue
	typedef struct packed {
		logic [IN_KEY_W-1:0] key;
		logic                last;
	} load_req_t;

	// one sorted result on the output channel
	typedef struct packed {
		logic [OUT_KEY_W-1:0] sorted_key;
		logic [POS_W-1:0]     source_position;
		logic                 last_result;
		logic                 overflowed;
	} sorted_res_t;
endpackage

// ===== sv/sse_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_stream_if: valid/ready channel
// Generic handshake channel with a typed payload.
// ----------------------------------------------------------------------------
interface sse_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/shell_sort_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_sort_engine: shell sort of a loaded key set
// Loads keys until a last mark, sorts with gaps 2^k-1, emits them in order.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// in_ch     in   valid/ready    key, last
// out_ch    out  valid/ready    sorted_key, source_position, last_result, overflowed
// apb       in   psel/penable   signed_keys at address 0
//
// Keys load at one per cycle through a two-entry queue while the back end loads.
// The sort runs on one single-port key memory: each compare step takes two reads,
// a compare and, on a swap, a write back. Output reads each key from memory and
// holds it until taken. arst_n clears all control state; memory content is not reset.
// No new request is taken from the queue while a set is sorted or emitted.
module shell_sort_engine #(
	parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEF,
	parameter int KEY_BITS  = sse_pkg::KEY_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sse_stream_if.sink                       in_ch,
	sse_stream_if.source                     out_ch,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sse_pkg::CFG_ADDR_W+1:0]   paddr,
	input  logic [sse_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [sse_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import sse_pkg::*;

	logic      signed_keys_q;
	logic      q_valid, q_ready;
	load_req_t q_req, in_req;
	logic      o_last, o_ovf;
	logic [OUT_KEY_W-1:0] o_key;
	logic [POS_W-1:0]     o_pos;

	assign pready = 1'b1;
	assign prdata = (paddr == {REG_SIGNED_KEYS, 2'b00}) ?
		{{(CFG_DATA_W-1){1'b0}}, signed_keys_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) signed_keys_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == {REG_SIGNED_KEYS, 2'b00})
			signed_keys_q <= pwdata[0];
	end

	assign in_req = in_ch.data;

	sse_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req(in_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	sse_back #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .signed_keys(signed_keys_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_key(o_key), .out_pos(o_pos), .out_last(o_last), .out_ovf(o_ovf)
	);

	assign out_ch.data.sorted_key      = o_key;
	assign out_ch.data.source_position = o_pos;
	assign out_ch.data.last_result     = o_last;
	assign out_ch.data.overflowed      = o_ovf;
endmodule

// ===== sv/sse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_front: input request queue
// Two-entry queue that takes load requests and feeds the sort back end.
// ----------------------------------------------------------------------------
module sse_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  sse_pkg::load_req_t         in_req,
	output logic                       q_valid,
	input  logic                       q_ready,
	output sse_pkg::load_req_t         q_req
);
	import sse_pkg::*;

	load_req_t  mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_req    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("full queue lost entry");
endmodule

// ===== sv/sse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_back: load store, shell sort sequencer and output stage
// Stores keys, runs gapped insertion over a memory, then streams results.
// ----------------------------------------------------------------------------
module sse_back #(
	parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEF,
	parameter int KEY_BITS  = sse_pkg::KEY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            signed_keys,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  sse_pkg::load_req_t              q_req,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sse_pkg::OUT_KEY_W-1:0]   out_key,
	output logic [sse_pkg::POS_W-1:0]       out_pos,
	output logic                            out_last,
	output logic                            out_ovf
);
	import sse_pkg::*;

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int GW = CW + 1;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_RD    = 7'b0000100,
		ST_CMP   = 7'b0001000,
		ST_WB    = 7'b0010000,
		ST_ORD   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [KEY_BITS-1:0] kmem [MAX_ITEMS];
	logic [POS_W-1:0]    pmem [MAX_ITEMS];

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [GW-1:0] gap_q;
	logic [CW-1:0] start_q;
	logic [CW:0]   at_q;
	logic [KEY_BITS-1:0] ka_q, kb_q;
	logic [POS_W-1:0]    pa_q, pb_q;
	logic          rd_sel_q;
	logic [CW-1:0] oidx_q;
	logic [KEY_BITS-1:0] ok_q;
	logic [POS_W-1:0]    op_q;
	logic          ov_q;

	logic [CW:0]   hi_idx;
	logic          below;
	logic          load_ok;
	logic [GW-1:0] top;
	logic          consume;
	logic [KEY_BITS-1:0] in_key;

	assign hi_idx = at_q + (CW+1)'(gap_q);

	// keep the low KEY_BITS bits of the request key, zero above
	always_comb begin
		in_key = '0;
		for (int i = 0; i < KEY_BITS; i++)
			if (i < IN_KEY_W) in_key[i] = q_req.key[i];
	end

	always_comb begin
		if (signed_keys) below = $signed(kb_q) < $signed(ka_q);
		else below = kb_q < ka_q;
	end

	// top = smallest power of two above the count
	always_comb begin
		top = GW'(1);
		for (int i = 0; i < GW; i++)
			if (top <= GW'(cnt_q)) top = top << 1;
	end

	assign q_ready = (state_q == ST_LOAD);
	assign load_ok = q_valid && q_ready && (cnt_q < CW'(MAX_ITEMS));
	assign consume = out_valid && out_ready;

	// memory port: at most one write or one registered read each cycle
	always_ff @(posedge clk) begin
		if (load_ok) begin
			kmem[cnt_q[IW-1:0]] <= in_key;
			pmem[cnt_q[IW-1:0]] <= POS_W'(cnt_q);
		end else if (state_q == ST_WB) begin
			kmem[at_q[IW-1:0]]   <= kb_q;
			pmem[at_q[IW-1:0]]   <= pb_q;
		end else if (state_q == ST_CMP && below) begin
			kmem[hi_idx[IW-1:0]] <= ka_q;
			pmem[hi_idx[IW-1:0]] <= pa_q;
		end
		if (state_q == ST_RD) begin
			if (!rd_sel_q) begin
				ka_q <= kmem[at_q[IW-1:0]];
				pa_q <= pmem[at_q[IW-1:0]];
			end else begin
				kb_q <= kmem[hi_idx[IW-1:0]];
				pb_q <= pmem[hi_idx[IW-1:0]];
			end
		end
		if (state_q == ST_ORD) begin
			ok_q <= kmem[oidx_q[IW-1:0]];
			op_q <= pmem[oidx_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			gap_q    <= '0;
			start_q  <= '0;
			at_q     <= '0;
			rd_sel_q <= 1'b0;
			oidx_q   <= '0;
			ov_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (q_valid) begin
						if (load_ok) cnt_q <= cnt_q + CW'(1);
						else ovf_q <= 1'b1;
						if (q_req.last) state_q <= ST_START;
					end
				end
				ST_START: begin
					gap_q   <= top - GW'(1);
					start_q <= '0;
					at_q    <= '0;
					rd_sel_q <= 1'b0;
					if (top == GW'(1)) state_q <= ST_LOAD; // empty set
					else state_q <= ST_RD;
				end
				ST_RD: begin
					// end a pass once no pair is left in range
					if ((CW+1)'(start_q) + (CW+1)'(gap_q) >= (CW+1)'(cnt_q)) begin
						if (gap_q == GW'(1)) begin
							oidx_q  <= '0;
							state_q <= ST_ORD;
						end else begin
							gap_q   <= gap_q >> 1;
							start_q <= '0;
							at_q    <= '0;
						end
					end else begin
						rd_sel_q <= ~rd_sel_q;
						if (rd_sel_q) state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (below) state_q <= ST_WB;
					else begin
						start_q <= start_q + CW'(1);
						at_q    <= (CW+1)'(start_q) + (CW+1)'(1);
						state_q <= ST_RD;
					end
				end
				ST_WB: begin
					// move down by gap while staying in range
					if (at_q >= (CW+1)'(gap_q)) begin
						at_q    <= at_q - (CW+1)'(gap_q);
						state_q <= ST_RD;
					end else begin
						start_q <= start_q + CW'(1);
						at_q    <= (CW+1)'(start_q) + (CW+1)'(1);
						state_q <= ST_RD;
					end
				end
				ST_ORD: begin
					ov_q    <= ovf_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (consume) begin
						if (oidx_q + CW'(1) == cnt_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							oidx_q  <= oidx_q + CW'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_valid = (state_q == ST_OUT);
	always_comb begin
		out_key = '0;
		for (int i = 0; i < OUT_KEY_W; i++)
			if (i < KEY_BITS) out_key[i] = ok_q[i];
	end
	assign out_pos  = op_q;
	assign out_last = (oidx_q + CW'(1) == cnt_q);
	assign out_ovf  = ov_q;

	a_out_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> oidx_q < cnt_q) else $error("output index beyond count");
	a_gap_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> gap_q[0]) else $error("gap not of form 2^k-1");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && out_last) |=> cnt_q == '0 && !ovf_q) else $error("set not cleared");
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |=> $stable(cnt_q) || state_q == ST_LOAD)
		else $error("count moved during sort");
endmodule
